/* sv/prt_pkg.sv */
// Package for the pending read tracker: entry record, sequencer states,
// request and status codes. No dependencies; imported by every other file.
package prt_pkg;

  // One stored outstanding read.
  typedef struct packed {
    logic [3:0]  device;
    logic [47:0] sector;
    logic [31:0] length;
    logic [3:0]  copy_disk;
    logic [47:0] copy_sector;
  } ent_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL_RD,
    S_FILL_CHK,
    S_SCAN,
    S_SHIFT,
    S_FILL_WR,
    S_NEXT,
    S_RESP
  } state_t;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_FIND = 1'b1;

  localparam logic [1:0] ST_ADDED   = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_MATCHED = 2'd2;
  localparam logic [1:0] ST_NOMATCH = 2'd3;

endpackage

/* sv/prt_ent_ram.sv */
// Entry store of the pending read tracker: simple dual-port synchronous RAM
// with one write port and one registered read port. Depends on prt_pkg.
module prt_ent_ram import prt_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  ent_t          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output ent_t          rdata
);

  ent_t mem [DEPTH];
  ent_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/pending_read_tracker.sv */
// Pending read tracker, top level: sequencer, fill count table, entry RAM.
// Depends on prt_pkg and prt_ent_ram.
// Sequence: an add steps through S_FILL_RD and S_FILL_CHK to S_RESP (straight to S_RESP
// for an out-of-range ring). A find-and-remove walks the rings through S_FILL_RD,
// S_FILL_CHK, S_SCAN (skipped if the ring is empty) and S_NEXT; on a hit it closes up
// with S_SHIFT (skipped when the hit is the newest entry) and S_FILL_WR before S_RESP.
// One request at a time; the next transfer is taken the cycle after the strobe, and the
// receiver cannot stall. Reset (rst_n low, synchronous) empties every ring at once.
module pending_read_tracker import prt_pkg::*; #(
  parameter int RING_DEPTH = 64,
  parameter int NUM_RINGS  = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [1:0]  in_ring_select,
  input  logic [3:0]  in_device_id,
  input  logic [47:0] in_sector,
  input  logic [31:0] in_length_bytes,
  input  logic [3:0]  in_mirror_disk_in,
  input  logic [47:0] in_mirror_sector_in,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [3:0]  out_mirror_disk_out,
  output logic [47:0] out_mirror_sector_out
);

  // All rings live back to back in one entry RAM; ring r starts at
  // r * RING_DEPTH. Fill counts live in a small table with one valid bit per
  // ring, so a ring never written reads as empty.
  localparam int SLOTS = NUM_RINGS * RING_DEPTH;
  localparam int AW    = $clog2(SLOTS);
  localparam int CW    = $clog2(RING_DEPTH + 1);
  localparam int RW    = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
  localparam int RCW   = $clog2(NUM_RINGS + 1);

  state_t state_r, state_nxt;

  // Latched request.
  logic        op_r, op_nxt;
  ent_t        req_r, req_nxt;

  // Search and close-up bookkeeping.
  logic [RCW-1:0] ring_r, ring_nxt;
  logic [AW-1:0]  base_r, base_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic           pend_r, pend_nxt;
  logic [CW-1:0]  pidx_r, pidx_nxt;

  // Result registers.
  logic [1:0]  res_status_r, res_status_nxt;
  logic [3:0]  res_mdisk_r, res_mdisk_nxt;
  logic [47:0] res_msec_r, res_msec_nxt;

  // Entry RAM ports.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  ent_t          ram_wdata, ram_rdata;

  // Fill count table.
  logic [CW-1:0]        fill_mem [NUM_RINGS];
  logic [NUM_RINGS-1:0] fill_vld_r;
  logic [CW-1:0]        fill_rd_r;
  logic                 fill_rvld_r;
  logic                 fill_we;
  logic [RW-1:0]        fill_addr;
  logic [CW-1:0]        fill_wdata;
  logic [CW-1:0]        fill_count;
  logic                 hit;

  prt_ent_ram #(
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The fill table is read every cycle at the current ring; the registered count
  // is used in the cycle after, in S_FILL_CHK.
  assign fill_addr  = RW'(ring_r);
  assign fill_count = fill_rvld_r ? fill_rd_r : '0;

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_addr] <= fill_wdata;
    end
    fill_rd_r   <= fill_mem[fill_addr];
    fill_rvld_r <= fill_vld_r[fill_addr];
  end

  // A compare is pending when the RAM data holds the entry at pidx_r.
  assign hit = pend_r && (ram_rdata.device == req_r.device) &&
               (ram_rdata.sector == req_r.sector) &&
               (ram_rdata.length == req_r.length);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    req_nxt        = req_r;
    ring_nxt       = ring_r;
    base_nxt       = base_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    pidx_nxt       = pidx_r;
    res_status_nxt = res_status_r;
    res_mdisk_nxt  = res_mdisk_r;
    res_msec_nxt   = res_msec_r;
    ram_we         = 1'b0;
    ram_waddr      = base_r + AW'(pidx_r);
    ram_wdata      = req_r;
    ram_re         = 1'b0;
    ram_raddr      = base_r + AW'(idx_r);
    fill_we        = 1'b0;
    fill_wdata     = cnt_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt              = in_req_type;
          req_nxt.device      = in_device_id;
          req_nxt.sector      = in_sector;
          req_nxt.length      = in_length_bytes;
          req_nxt.copy_disk   = in_mirror_disk_in;
          req_nxt.copy_sector = in_mirror_sector_in;
          res_mdisk_nxt       = '0;
          res_msec_nxt        = '0;
          if (in_req_type == OP_ADD) begin
            ring_nxt = RCW'(in_ring_select);
            base_nxt = AW'(32'(in_ring_select) * RING_DEPTH);
            if ({30'd0, in_ring_select} >= 32'(NUM_RINGS)) begin
              res_status_nxt = ST_DROPPED;
              state_nxt      = S_RESP;
            end else begin
              state_nxt = S_FILL_RD;
            end
          end else begin
            ring_nxt  = '0;
            base_nxt  = '0;
            state_nxt = S_FILL_RD;
          end
        end
      end

      S_FILL_RD: begin
        state_nxt = S_FILL_CHK;
      end

      S_FILL_CHK: begin
        if (op_r == OP_ADD) begin
          if (fill_count >= CW'(RING_DEPTH)) begin
            res_status_nxt = ST_DROPPED;
          end else begin
            ram_we         = 1'b1;
            ram_waddr      = base_r + AW'(fill_count);
            fill_we        = 1'b1;
            fill_wdata     = fill_count + 1'b1;
            res_status_nxt = ST_ADDED;
          end
          state_nxt = S_RESP;
        end else begin
          cnt_nxt  = fill_count;
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          if (fill_count == '0) begin
            state_nxt = S_NEXT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      // Streamed search: read one entry a cycle, compare the one read
      // the cycle before.
      S_SCAN: begin
        if (idx_r != cnt_r) begin
          ram_re   = 1'b1;
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = idx_r;
        end else begin
          pend_nxt = 1'b0;
        end
        if (hit) begin
          res_status_nxt = ST_MATCHED;
          res_mdisk_nxt  = ram_rdata.copy_disk;
          res_msec_nxt   = ram_rdata.copy_sector;
          if (pidx_r + 1'b1 == cnt_r) begin
            state_nxt = S_FILL_WR;
          end else begin
            idx_nxt   = pidx_r + 1'b1;
            pend_nxt  = 1'b0;
            state_nxt = S_SHIFT;
          end
        end else if (idx_r == cnt_r) begin
          state_nxt = S_NEXT;
        end
      end

      // Close-up: read slot idx_r while writing the slot read the cycle
      // before one place lower.
      S_SHIFT: begin
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = base_r + AW'(pidx_r);
          ram_wdata = ram_rdata;
        end
        if (idx_r != cnt_r) begin
          ram_re   = 1'b1;
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = idx_r - 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_FILL_WR;
        end
      end

      S_FILL_WR: begin
        fill_we    = 1'b1;
        fill_wdata = cnt_r - 1'b1;
        state_nxt  = S_RESP;
      end

      S_NEXT: begin
        ring_nxt = ring_r + 1'b1;
        base_nxt = base_r + AW'(RING_DEPTH);
        if (ring_r == RCW'(NUM_RINGS - 1)) begin
          res_status_nxt = ST_NOMATCH;
          state_nxt      = S_RESP;
        end else begin
          state_nxt = S_FILL_RD;
        end
      end

      S_RESP: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pend_r     <= 1'b0;
      fill_vld_r <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      if (fill_we) begin
        fill_vld_r[fill_addr] <= 1'b1;
      end
    end
  end

  // Payload and bookkeeping registers; only meaningful inside a request.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    req_r        <= req_nxt;
    ring_r       <= ring_nxt;
    base_r       <= base_nxt;
    cnt_r        <= cnt_nxt;
    idx_r        <= idx_nxt;
    pidx_r       <= pidx_nxt;
    res_status_r <= res_status_nxt;
    res_mdisk_r  <= res_mdisk_nxt;
    res_msec_r   <= res_msec_nxt;
  end

  // The result transfer takes place in the single S_RESP cycle.
  assign busy                  = (state_r != S_IDLE);
  assign out_valid             = (state_r == S_RESP);
  assign out_status            = res_status_r;
  assign out_mirror_disk_out   = res_mdisk_r;
  assign out_mirror_sector_out = res_msec_r;

endmodule

/* sv/prt_checker.sv */
// Port-level checks for the pending read tracker and the bind that attaches
// them to the top level. Depends on prt_pkg and pending_read_tracker.
module prt_checker import prt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [3:0]  out_mirror_disk_out,
  input logic [47:0] out_mirror_sector_out
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_result_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside a request");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe not followed by release");

  a_mirror_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_MATCHED) |->
      (out_mirror_disk_out == 4'd0) && (out_mirror_sector_out == 48'd0))
    else $error("mirror fields nonzero without a match");

endmodule

bind pending_read_tracker prt_checker u_prt_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .start                 (start),
  .busy                  (busy),
  .out_valid             (out_valid),
  .out_status            (out_status),
  .out_mirror_disk_out   (out_mirror_disk_out),
  .out_mirror_sector_out (out_mirror_sector_out)
);

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for pending_read_tracker: a directed table, ring fills
// past full, then random add and find-and-remove traffic checked by a ring model.
// Depends on prt_pkg and the pending_read_tracker RTL; reads no files.
module testbench;
  import prt_pkg::*;

  localparam int RING_DEPTH = 64;
  localparam int NUM_RINGS = 4;
  // Longest find-and-remove: every ring full and the hit in the last ring,
  // anywhere but its newest entry.
  localparam int SEARCH_CYCLES = (NUM_RINGS - 1) * (RING_DEPTH + 4) + RING_DEPTH + 6;
  // Cycles without any transfer before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 5 * SEARCH_CYCLES;
  localparam int MAX_REPORTS = 10;
  localparam int MIXED_PER_PHASE = 240;

  // One request as the block's input ports see it.
  typedef struct packed {
    logic        op;
    logic [1:0]  ring;
    logic [3:0]  device;
    logic [47:0] sector;
    logic [31:0] length;
    logic [3:0]  copy_disk;
    logic [47:0] copy_sector;
  } read_req_t;

  // One response as the block's result ports show it.
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  copy_disk;
    logic [47:0] copy_sector;
  } read_result_t;

  // The match key of an outstanding read.
  typedef struct packed {
    logic [3:0]  device;
    logic [47:0] sector;
    logic [31:0] length;
  } read_key_t;

  // A directed row. When pinned is set, the typed response is what the block
  // must return; otherwise the ring model decides.
  typedef struct {
    read_req_t    req;
    bit           pinned;
    read_result_t want;
  } directed_row_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         start;
  logic         busy;
  read_req_t    cur_req;
  bit           cur_pinned;
  read_result_t cur_want;
  logic         out_valid;
  logic [1:0]   out_status;
  logic [3:0]   out_mirror_disk_out;
  logic [47:0]  out_mirror_sector_out;

  // Ring model: one list of outstanding reads per ring, oldest at slot 0.
  ent_t ring_entries [NUM_RINGS][RING_DEPTH];
  int   ring_fill [NUM_RINGS];

  read_result_t  pending_results[$];  // responses still owed by the block, oldest first
  read_key_t     live_keys[$];        // keys the stimulus believes are still stored
  directed_row_t directed_rows[$];

  int mismatch_count = 0;
  int stall_cycles = 0;
  int sender_idle_pct = 0;

  always #5 clk = ~clk;

  pending_read_tracker #(
    .RING_DEPTH(RING_DEPTH),
    .NUM_RINGS (NUM_RINGS)
  ) u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_req_type          (cur_req.op),
    .in_ring_select       (cur_req.ring),
    .in_device_id         (cur_req.device),
    .in_sector            (cur_req.sector),
    .in_length_bytes      (cur_req.length),
    .in_mirror_disk_in    (cur_req.copy_disk),
    .in_mirror_sector_in  (cur_req.copy_sector),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_mirror_disk_out  (out_mirror_disk_out),
    .out_mirror_sector_out(out_mirror_sector_out)
  );

  // Applies one accepted request to the ring model and returns the response
  // the block owes for it. An add appends to its ring unless the ring is full.
  // A find walks ring 0 upward, oldest entry first, removes the first hit and
  // shifts the younger entries of that ring down one slot.
  function automatic read_result_t service_request(input read_req_t r);
    read_result_t res;
    bit           found;
    ent_t         e;
    res = '{status: ST_NOMATCH, copy_disk: '0, copy_sector: '0};
    if (r.op == OP_ADD) begin
      if (int'(r.ring) >= NUM_RINGS || ring_fill[r.ring] >= RING_DEPTH) begin
        res.status = ST_DROPPED;
      end else begin
        e.device = r.device;
        e.sector = r.sector;
        e.length = r.length;
        e.copy_disk = r.copy_disk;
        e.copy_sector = r.copy_sector;
        ring_entries[r.ring][ring_fill[r.ring]] = e;
        ring_fill[r.ring]++;
        res.status = ST_ADDED;
      end
    end else begin
      found = 1'b0;
      for (int rg = 0; rg < NUM_RINGS && !found; rg++) begin
        for (int i = 0; i < ring_fill[rg] && !found; i++) begin
          e = ring_entries[rg][i];
          if (e.device == r.device && e.sector == r.sector && e.length == r.length) begin
            res = '{status: ST_MATCHED, copy_disk: e.copy_disk,
                    copy_sector: e.copy_sector};
            for (int j = i; j + 1 < ring_fill[rg]; j++)
              ring_entries[rg][j] = ring_entries[rg][j + 1];
            ring_fill[rg]--;
            found = 1'b1;
          end
        end
      end
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Monitor and scoreboard. Inputs change on the falling edge, so at the
  // rising edge both the request transfer and the response strobe are stable.
  // A response can never share an edge with the request that caused it, so
  // handling the response first is safe.
  always @(posedge clk) begin
    read_result_t want;
    bit           moved;
    if (rst_n === 1'b1) begin
      moved = 1'b0;
      if (out_valid === 1'b1) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: unexpected response, status %0h disk %0h sector %0h", $time,
                     out_status, out_mirror_disk_out, out_mirror_sector_out);
        end else begin
          want = pending_results.pop_front();
          check_field("status", 48'(want.status), 48'(out_status));
          check_field("mirror disk", 48'(want.copy_disk), 48'(out_mirror_disk_out));
          check_field("mirror sector", want.copy_sector, out_mirror_sector_out);
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        moved = 1'b1;
        // The model always advances; a pinned row only overrides what is owed.
        want = service_request(cur_req);
        pending_results.push_back(cur_pinned ? cur_want : want);
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Presents one request and returns at the falling edge after its transfer.
  // busy only moves on a rising edge, so its value at the falling edge is the
  // one the next rising edge sees: the request goes through there exactly when
  // busy is low now.
  task automatic send_request(input read_req_t r, input bit pinned,
                              input read_result_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    cur_req <= r;
    cur_pinned <= pinned;
    cur_want <= want;
    start <= 1'b1;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  // Holds the request side quiet until every owed response has come back.
  // It always lets at least one edge pass, so start never gets two updates
  // in one time step.
  task automatic drain_responses();
    start <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  // Keys mix full-range values with a few small ones, so that repeated keys
  // and duplicate entries come up by themselves.
  function automatic read_key_t random_key();
    read_key_t   k;
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    k.device = 4'($urandom_range(15));
    k.sector = ($urandom_range(1) != 0) ? wide[47:0] : 48'($urandom_range(7));
    k.length = ($urandom_range(1) != 0) ? 32'($urandom) : 32'(512 << $urandom_range(4));
    return k;
  endfunction

  // One bit flipped in one part of the key.
  function automatic read_key_t near_miss(input read_key_t k);
    case ($urandom_range(2))
      0: k.device ^= 4'(1 << $urandom_range(3));
      1: k.sector ^= 48'(1) << $urandom_range(47);
      default: k.length ^= 32'(1) << $urandom_range(31);
    endcase
    return k;
  endfunction

  // The mirror fields are random on finds as well; the block must ignore them.
  function automatic read_req_t make_request(input logic op, input logic [1:0] ring,
                                             input read_key_t k);
    read_req_t   r;
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    r.op = op;
    r.ring = ring;
    r.device = k.device;
    r.sector = k.sector;
    r.length = k.length;
    r.copy_disk = 4'($urandom_range(15));
    r.copy_sector = wide[47:0];
    return r;
  endfunction

  task automatic add_row(input logic op, input logic [1:0] ring, input read_key_t k,
                         input logic [3:0] md, input logic [47:0] ms, input bit pinned,
                         input logic [1:0] st, input logic [3:0] wd,
                         input logic [47:0] ws);
    directed_row_t row;
    row.req = '{op: op, ring: ring, device: k.device, sector: k.sector, length: k.length,
                copy_disk: md, copy_sector: ms};
    row.pinned = pinned;
    row.want = '{status: st, copy_disk: wd, copy_sector: ws};
    directed_rows.push_back(row);
  endtask

  // One random request. Most of the traffic adds keys or removes keys known
  // to be stored; the rest are near misses, duplicates and stray keys. The add
  // share follows the pool size so the rings neither drain nor stay full.
  task automatic send_mixed();
    int        add_pct;
    int        pick;
    int        idx;
    read_key_t k;
    add_pct = (live_keys.size() < 16) ? 75 : (live_keys.size() > 150) ? 20 : 45;
    pick = $urandom_range(99);
    if (pick < add_pct) begin
      if (live_keys.size() != 0 && $urandom_range(99) < 15)
        k = live_keys[$urandom_range(live_keys.size() - 1)];
      else
        k = random_key();
      live_keys.push_back(k);
      send_request(make_request(OP_ADD, 2'($urandom_range(3)), k), 1'b0, '0);
    end else begin
      pick = $urandom_range(99);
      if (live_keys.size() != 0 && pick < 85) begin
        idx = $urandom_range(live_keys.size() - 1);
        k = live_keys[idx];
        if (pick < 70)
          live_keys.delete(idx);
        else
          k = near_miss(k);
      end else begin
        k = random_key();
      end
      send_request(make_request(OP_FIND, 2'($urandom_range(3)), k), 1'b0, '0);
    end
  endtask

  initial begin
    read_key_t zero_key;
    read_key_t ones_key;
    read_key_t key_a;
    read_key_t key_b;
    read_key_t key_b_off;
    read_key_t key_c1;
    read_key_t key_c2;
    read_key_t key_c3;
    read_key_t k;
    int        idle_plan[4];

    rst_n = 1'b0;
    start = 1'b0;
    cur_req = '0;
    cur_pinned = 1'b0;
    cur_want = '0;
    foreach (ring_fill[i]) ring_fill[i] = 0;

    zero_key = '0;
    ones_key = '1;
    key_a = '{device: 4'd5, sector: 48'h0000_1234_5678, length: 32'd4096};
    key_b = '{device: 4'd9, sector: 48'h8000_0000_0001, length: 32'd512};
    key_c1 = '{device: 4'd2, sector: 48'd100, length: 32'd8};
    key_c2 = '{device: 4'd2, sector: 48'd101, length: 32'd8};
    key_c3 = '{device: 4'd2, sector: 48'd102, length: 32'd8};

    // Directed table. A find right after reset has nothing to hit; adds to
    // empty rings always go in; the all-zero and all-one entries come back
    // unchanged. Key A sits twice in ring 1 and once in ring 2, so the first three
    // finds of A show the lowest ring and the oldest entry winning. Key B is
    // probed with one bit off in each part of the key before the real hit.
    // Ring 0 gets C1..C3 and loses the middle one first to exercise close-up.
    add_row(OP_FIND, 2'd0, zero_key, 4'h0, 48'h0, 1'b1, ST_NOMATCH, 4'h0, 48'h0);
    add_row(OP_ADD, 2'd0, zero_key, 4'h0, 48'h0, 1'b1, ST_ADDED, 4'h0, 48'h0);
    add_row(OP_ADD, 2'd3, ones_key, 4'hF, '1, 1'b1, ST_ADDED, 4'h0, 48'h0);
    add_row(OP_ADD, 2'd1, key_a, 4'h1, 48'h111, 1'b1, ST_ADDED, 4'h0, 48'h0);
    add_row(OP_ADD, 2'd2, key_a, 4'h2, 48'h222, 1'b1, ST_ADDED, 4'h0, 48'h0);
    add_row(OP_ADD, 2'd1, key_a, 4'h3, 48'h333, 1'b1, ST_ADDED, 4'h0, 48'h0);
    add_row(OP_FIND, 2'd3, key_a, 4'hF, '1, 1'b0, ST_NOMATCH, 4'h0, 48'h0);
    add_row(OP_FIND, 2'd0, key_a, 4'h0, 48'h0, 1'b0, ST_NOMATCH, 4'h0, 48'h0);
    add_row(OP_FIND, 2'd2, key_a, 4'hA, 48'h5555, 1'b0, ST_NOMATCH, 4'h0, 48'h0);
    add_row(OP_FIND, 2'd1, key_a, 4'h0, 48'h0, 1'b1, ST_NOMATCH, 4'h0, 48'h0);
    add_row(OP_FIND, 2'd0, ones_key, 4'h0, 48'h0, 1'b1, ST_MATCHED, 4'hF, '1);
    add_row(OP_FIND, 2'd3, zero_key, 4'hF, '1, 1'b1, ST_MATCHED, 4'h0, 48'h0);
    add_row(OP_ADD, 2'd0, key_b, 4'h4, 48'hABCD_EF01_2345, 1'b1, ST_ADDED, 4'h0, 48'h0);
    key_b_off = key_b;
    key_b_off.sector ^= 48'h1;
    add_row(OP_FIND, 2'd0, key_b_off, 4'h0, 48'h0, 1'b1, ST_NOMATCH, 4'h0, 48'h0);
    key_b_off = key_b;
    key_b_off.length ^= 32'h8000_0000;
    add_row(OP_FIND, 2'd0, key_b_off, 4'h0, 48'h0, 1'b1, ST_NOMATCH, 4'h0, 48'h0);
    key_b_off = key_b;
    key_b_off.device ^= 4'h8;
    add_row(OP_FIND, 2'd0, key_b_off, 4'h0, 48'h0, 1'b1, ST_NOMATCH, 4'h0, 48'h0);
    add_row(OP_FIND, 2'd2, key_b, 4'h0, 48'h0, 1'b0, ST_NOMATCH, 4'h0, 48'h0);
    add_row(OP_ADD, 2'd0, key_c1, 4'h5, 48'h500, 1'b1, ST_ADDED, 4'h0, 48'h0);
    add_row(OP_ADD, 2'd0, key_c2, 4'h6, 48'h600, 1'b1, ST_ADDED, 4'h0, 48'h0);
    add_row(OP_ADD, 2'd0, key_c3, 4'h7, 48'h700, 1'b1, ST_ADDED, 4'h0, 48'h0);
    add_row(OP_FIND, 2'd1, key_c2, 4'h0, 48'h0, 1'b0, ST_NOMATCH, 4'h0, 48'h0);
    add_row(OP_FIND, 2'd0, key_c3, 4'h0, 48'h0, 1'b0, ST_NOMATCH, 4'h0, 48'h0);
    add_row(OP_FIND, 2'd0, key_c1, 4'h0, 48'h0, 1'b0, ST_NOMATCH, 4'h0, 48'h0);
    add_row(OP_FIND, 2'd0, key_c1, 4'h0, 48'h0, 1'b1, ST_NOMATCH, 4'h0, 48'h0);

    // Synchronous reset, released on a falling edge.
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].pinned, directed_rows[i].want);
    drain_responses();

    // Fill every ring past its depth so the last adds are dropped, with the
    // sender pacing varied from ring to ring. The full rings then make every
    // find search deep, and the mixed traffic below drains them.
    idle_plan = '{0, 50, 36, 20};
    for (int rg = 0; rg < NUM_RINGS; rg++) begin
      sender_idle_pct = idle_plan[rg];
      repeat (RING_DEPTH + 3) begin
        k = random_key();
        live_keys.push_back(k);
        send_request(make_request(OP_ADD, 2'(rg), k), 1'b0, '0);
      end
    end

    // Mixed traffic in phases of sender pacing, each ending with a pause
    // until every owed response has come back.
    idle_plan = '{0, 50, 36, 0};
    foreach (idle_plan[p]) begin
      sender_idle_pct = idle_plan[p];
      repeat (MIXED_PER_PHASE) send_mixed();
      drain_responses();
    end

    // Everything has been sent. Wait out any stray response the block might
    // still produce; the watchdog bounds the wait for owed responses.
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SEARCH_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

/* files.f */
sv/prt_pkg.sv
sv/prt_ent_ram.sv
sv/pending_read_tracker.sv
sv/prt_checker.sv
tb/testbench.sv
